@@ src/thermocouple_sample_linearizer_macros.svh @@
// Assertion macros shared by the thermocouple linearizer RTL.
`ifndef THERMOCOUPLE_SAMPLE_LINEARIZER_MACROS_SVH
`define THERMOCOUPLE_SAMPLE_LINEARIZER_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define TSL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thermocouple linearizer assertion failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define TSL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thermocouple linearizer assertion failed");

`endif

@@ src/tsl_pkg.sv @@
// Shared types, constants and the voltage/temperature table of the linearizer.
package tsl_pkg;

    localparam int ADC_W         = 12;
    localparam int OUT_W         = 13;
    localparam int TIME_W        = 32;
    localparam int OFFSET_W      = 12;
    localparam int GAIN_W        = 10;
    localparam int BLANK_W       = 10;
    localparam int CFG_DATA_W    = 12;
    localparam int CFG_IDX_W     = 2;
    localparam int FULL_SCALE_MV = 3300;
    localparam int UV_PER_MV     = 1000;
    localparam int Q4_SHIFT      = 4;

    // adc * 3300 fits 24 bits; times 1000 fits 34 bits
    localparam int POS_W = ADC_W + 12;
    localparam int NUM_W = POS_W + 10;

    localparam int TABLE_POINTS = 11;
    localparam int IDX_W        = $clog2(TABLE_POINTS);
    localparam int UV_W         = 13;
    localparam int TEMP_W       = 9;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK  = 2'd2;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 12'd100;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 10'd200;
    localparam logic [BLANK_W-1:0]  BLANK_RESET  = 10'd50;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [UV_W-1:0] tc_volt(input logic [IDX_W-1:0] idx);
        logic [UV_W-1:0] v;
        case (idx)
            4'd0:    v = 13'd0;
            4'd1:    v = 13'd250;
            4'd2:    v = 13'd1000;
            4'd3:    v = 13'd2000;
            4'd4:    v = 13'd3000;
            4'd5:    v = 13'd4000;
            4'd6:    v = 13'd5000;
            4'd7:    v = 13'd5500;
            4'd8:    v = 13'd6320;
            4'd9:    v = 13'd7000;
            4'd10:   v = 13'd8000;
            default: v = 13'd8000;
        endcase
        return v;
    endfunction

    function automatic logic [TEMP_W-1:0] tc_temp(input logic [IDX_W-1:0] idx);
        logic [TEMP_W-1:0] t;
        case (idx)
            4'd0:    t = 9'd0;
            4'd1:    t = 9'd38;
            4'd2:    t = 9'd84;
            4'd3:    t = 9'd134;
            4'd4:    t = 9'd176;
            4'd5:    t = 9'd218;
            4'd6:    t = 9'd262;
            4'd7:    t = 9'd280;
            4'd8:    t = 9'd334;
            4'd9:    t = 9'd352;
            4'd10:   t = 9'd380;
            default: t = 9'd380;
        endcase
        return t;
    endfunction

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_POINTS - 1);

endpackage

@@ src/tsl_div.sv @@
// Restoring divider, one quotient bit per cycle.
module tsl_div import tsl_pkg::*; #(
    parameter int N_W = 34,
    parameter int D_W = 26
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic [N_W-1:0] quotient,
    output div_stat_t      stat
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   quo_reg, quo_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [D_W-1:0]   dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [D_W:0]     rem_sh;
    logic [D_W:0]     rem_sub;

    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[N_W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(N_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // keep the partial remainder below the divisor
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sub[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ src/thermocouple_sample_linearizer.sv @@
// Top level: blanking check, voltage conversion and table interpolation.
//
// Input beat (in_valid/in_ready): adc_sample, heater_on, now_ms. A beat with
// heater_on set stores now_ms as the last heating time. A sample whose age
// since the last heating time is at most blanking_ms gives no result.
// Output beat (out_valid/out_ready): temperature_q4 in 1/16 degree C, 0..6080.
// Configuration: cfg_we writes cfg_data into the register picked by cfg_index
// (0 offset_millivolts, 1 amplifier_gain, 2 blanking_ms); write only when idle.
// Rate: one item at a time; in_ready returns in the cycle the result loads.
// A blanked item frees the input straight from the check state. With a free
// output, a result appears after three multiply steps when the reading is at
// or below the offset, after four and one divider run when the quotient
// clamps at an end of the table, and otherwise after five multiply steps on
// a shared multiplier, two runs of the shared restoring divider, a segment
// search and the load of the output register.
// in_ready is high only while the sequencer idles; the output register lets
// the next item enter while a result waits. If the receiver stalls, the
// following result holds in the sequencer until the output register frees.
// Reset restores offset 100 mV, gain 200, blanking 50 ms, clears the last
// heating time and drops any pending result.
`include "thermocouple_sample_linearizer_macros.svh"
module thermocouple_sample_linearizer import tsl_pkg::*; #(
    parameter int ADC_FULL_SCALE = 4095
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ADC_W-1:0]      adc_sample,
    input  logic                  heater_on,
    input  logic [TIME_W-1:0]     now_ms,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_W-1:0]      temperature_q4
);

    localparam int FS_W  = $clog2(ADC_FULL_SCALE + 1);
    localparam int MB_W  = (FS_W > 12) ? FS_W : 12;
    localparam int PROD_W = POS_W + MB_W;
    localparam int NEG_W = OFFSET_W + FS_W;
    localparam int DEN_W = FS_W + GAIN_W;
    localparam int CMP_W = (NEG_W > POS_W) ? NEG_W : POS_W;
    localparam logic [FS_W-1:0] FS_VAL = FS_W'(ADC_FULL_SCALE);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] S_CHECK = 4'd1;
    localparam logic [ST_W-1:0] S_POS   = 4'd2;
    localparam logic [ST_W-1:0] S_NEG   = 4'd3;
    localparam logic [ST_W-1:0] S_DEN   = 4'd4;
    localparam logic [ST_W-1:0] S_NUM   = 4'd5;
    localparam logic [ST_W-1:0] S_DIV1  = 4'd6;
    localparam logic [ST_W-1:0] S_SEEK  = 4'd7;
    localparam logic [ST_W-1:0] S_FRAC  = 4'd8;
    localparam logic [ST_W-1:0] S_DIV2  = 4'd9;
    localparam logic [ST_W-1:0] S_EMIT  = 4'd10;

    logic [ST_W-1:0]     state_reg, state_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [GAIN_W-1:0]   gain_reg, gain_next;
    logic [BLANK_W-1:0]  blank_reg, blank_next;
    logic [TIME_W-1:0]   last_heat_reg, last_heat_next;
    logic                out_valid_reg, out_valid_next;
    logic [ADC_W-1:0]    adc_reg, adc_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [NEG_W-1:0]    neg_reg, neg_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic [UV_W-1:0]     uv_reg, uv_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [OUT_W-1:0]    res_reg, res_next;
    logic [OUT_W-1:0]    temp_out_reg, temp_out_next;

    logic [POS_W-1:0]    mul_a;
    logic [MB_W-1:0]     mul_b;
    logic [PROD_W-1:0]   prod;
    logic [GAIN_W-1:0]   gain_eff;
    logic [TIME_W-1:0]   elapsed;
    logic [IDX_W-1:0]    idx_up;
    logic [UV_W-1:0]     v_lo;
    logic [UV_W-1:0]     v_hi;
    logic [TEMP_W-1:0]   t_lo;
    logic [TEMP_W-1:0]   t_rise;
    logic                emit_load;
    logic                div_start;
    logic [NUM_W-1:0]    div_dividend;
    logic [DEN_W-1:0]    div_divisor;
    logic [NUM_W-1:0]    div_quot;
    div_stat_t           div_stat;

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign temperature_q4 = temp_out_reg;

    assign gain_eff = (gain_reg == '0) ? GAIN_W'(1) : gain_reg;
    assign elapsed  = now_reg - last_heat_reg;
    assign idx_up   = idx_reg + IDX_W'(1);
    assign v_lo     = tc_volt(idx_reg);
    assign v_hi     = tc_volt(idx_up);
    assign t_lo     = tc_temp(idx_reg);
    assign t_rise   = tc_temp(idx_up) - tc_temp(idx_reg);

    // shared multiplier, operands picked by the sequencer
    always_comb
    begin
        case (state_reg)
            S_POS:
            begin
                mul_a = POS_W'(adc_reg);
                mul_b = MB_W'(FULL_SCALE_MV);
            end
            S_NEG:
            begin
                mul_a = POS_W'(offset_reg);
                mul_b = MB_W'(FS_VAL);
            end
            S_DEN:
            begin
                mul_a = POS_W'(FS_VAL);
                mul_b = MB_W'(gain_eff);
            end
            S_NUM:
            begin
                mul_a = POS_W'(pos_reg - POS_W'(neg_reg));
                mul_b = MB_W'(UV_PER_MV);
            end
            S_FRAC:
            begin
                mul_a = POS_W'(uv_reg - v_lo);
                mul_b = MB_W'({t_rise, {Q4_SHIFT{1'b0}}});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod         = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign div_start    = (state_reg == S_NUM) || (state_reg == S_FRAC);
    assign div_dividend = prod[NUM_W-1:0];
    assign div_divisor  = (state_reg == S_FRAC) ? DEN_W'(v_hi - v_lo) : den_reg;
    assign emit_load    = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    tsl_div #(
        .N_W (NUM_W),
        .D_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        offset_next    = offset_reg;
        gain_next      = gain_reg;
        blank_next     = blank_reg;
        last_heat_next = last_heat_reg;
        adc_next       = adc_reg;
        now_next       = now_reg;
        pos_next       = pos_reg;
        neg_next       = neg_reg;
        den_next       = den_reg;
        uv_next        = uv_reg;
        idx_next       = idx_reg;
        res_next       = res_reg;
        temp_out_next  = temp_out_reg;
        out_valid_next = out_valid_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_OFFSET: offset_next = cfg_data[OFFSET_W-1:0];
                REG_GAIN:   gain_next   = cfg_data[GAIN_W-1:0];
                REG_BLANK:  blank_next  = cfg_data[BLANK_W-1:0];
                default:    ;
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (emit_load)
        begin
            out_valid_next = 1'b1;
            temp_out_next  = res_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    adc_next   = adc_sample;
                    now_next   = now_ms;
                    if (heater_on)
                        last_heat_next = now_ms;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // drop samples still inside the blanking window
                if (elapsed <= TIME_W'(blank_reg))
                    state_next = S_IDLE;
                else
                    state_next = S_POS;
            end
            S_POS:
            begin
                pos_next   = prod[POS_W-1:0];
                state_next = S_NEG;
            end
            S_NEG:
            begin
                neg_next   = prod[NEG_W-1:0];
                state_next = S_DEN;
            end
            S_DEN:
            begin
                den_next = prod[DEN_W-1:0];
                if (CMP_W'(pos_reg) <= CMP_W'(neg_reg))
                begin
                    res_next   = '0;
                    state_next = S_EMIT;
                end
                else
                    state_next = S_NUM;
            end
            S_NUM:
            begin
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                if (div_stat.done)
                begin
                    if (div_quot >= NUM_W'(tc_volt(LAST_IDX)))
                    begin
                        res_next   = OUT_W'({tc_temp(LAST_IDX), {Q4_SHIFT{1'b0}}});
                        state_next = S_EMIT;
                    end
                    else if (div_quot == '0)
                    begin
                        res_next   = OUT_W'({tc_temp('0), {Q4_SHIFT{1'b0}}});
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        uv_next    = div_quot[UV_W-1:0];
                        idx_next   = '0;
                        state_next = S_SEEK;
                    end
                end
            end
            S_SEEK:
            begin
                // advance to the first segment whose upper point covers uv
                if (uv_reg <= v_hi)
                    state_next = S_FRAC;
                else
                    idx_next = idx_up;
            end
            S_FRAC:
            begin
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                if (div_stat.done)
                begin
                    res_next   = OUT_W'({t_lo, {Q4_SHIFT{1'b0}}}) + div_quot[OUT_W-1:0];
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            offset_reg    <= OFFSET_RESET;
            gain_reg      <= GAIN_RESET;
            blank_reg     <= BLANK_RESET;
            last_heat_reg <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            offset_reg    <= offset_next;
            gain_reg      <= gain_next;
            blank_reg     <= blank_next;
            last_heat_reg <= last_heat_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        adc_reg      <= adc_next;
        now_reg      <= now_next;
        pos_reg      <= pos_next;
        neg_reg      <= neg_next;
        den_reg      <= den_next;
        uv_reg       <= uv_next;
        res_reg      <= res_next;
        temp_out_reg <= temp_out_next;
    end

    `TSL_ASSERT_NXT(a_heat_store, in_valid && in_ready && heater_on,
        last_heat_reg == $past(now_ms))
    `TSL_ASSERT_IMP(a_result_range, out_valid_reg,
        temp_out_reg <= OUT_W'({tc_temp(LAST_IDX), {Q4_SHIFT{1'b0}}}))
    `TSL_ASSERT_IMP(a_div_start_free, div_start, !div_stat.busy)
    `TSL_ASSERT_IMP(a_seek_bound, state_reg == S_SEEK || state_reg == S_FRAC,
        idx_reg < LAST_IDX)
    `TSL_ASSERT_IMP(a_emit_hold, state_reg == S_EMIT && out_valid_reg && !out_ready,
        state_next == S_EMIT)

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the thermocouple sample linearizer: directed probes, then random phases.
module testbench;
    import tsl_pkg::*;

    localparam int          ADC_FS     = 4095;
    localparam int          SEG_LAST   = TABLE_POINTS - 1;
    localparam int          SETTLE_CYC = 120;
    localparam int          HOLD_CYC   = 400;
    localparam int          PHASES     = 8;
    localparam int          PHASE_LEN  = 56;

    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_VALUE} probe_check_t;

    typedef struct {
        logic [OFFSET_W-1:0] offset;
        logic [GAIN_W-1:0]   gain;
        logic [BLANK_W-1:0]  blank;
        logic [ADC_W-1:0]    adc;
        logic                heat;
        logic [TIME_W-1:0]   now;
        probe_check_t        check;
        logic [OUT_W-1:0]    temp;
    } probe_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_OFFSET;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [ADC_W-1:0]      adc_sample = '0;
    logic                  heater_on = 1'b0;
    logic [TIME_W-1:0]     now_ms = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [OUT_W-1:0]      temperature_q4;

    // thermocouple curve: microvolts against whole degrees
    int unsigned seg_uv [TABLE_POINTS] = '{0, 250, 1000, 2000, 3000, 4000, 5000, 5500,
                                           6320, 7000, 8000};
    int unsigned seg_deg[TABLE_POINTS] = '{0, 38, 84, 134, 176, 218, 262, 280,
                                           334, 352, 380};

    logic [OFFSET_W-1:0] offset_mv;
    logic [GAIN_W-1:0]   gain_reg;
    logic [BLANK_W-1:0]  blank_ms;
    logic [TIME_W-1:0]   last_heat_ms;
    logic [TIME_W-1:0]   clock_ms;

    logic [OUT_W-1:0] temp_due[$];
    probe_row_t       probes[$];
    int unsigned      mismatches = 0;
    int unsigned      tx_idle_pct = 0;
    int unsigned      rx_stall_pct = 0;
    logic             hold_req = 1'b0;
    logic             hold_done = 1'b0;
    int unsigned      hold_left = 0;

    thermocouple_sample_linearizer #(
        .ADC_FULL_SCALE (ADC_FS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .adc_sample     (adc_sample),
        .heater_on      (heater_on),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .temperature_q4 (temperature_q4)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // Blanking check, conversion to microvolts and table lookup; updates the heating time.
    function automatic logic linearize_sample(input logic [ADC_W-1:0] adc, input logic heat,
                                              input logic [TIME_W-1:0] now,
                                              output logic [OUT_W-1:0] temp);
        longint unsigned pos, neg, uv, div, q, lo, hi;
        logic [TIME_W-1:0] age;
        logic              found;
        temp = '0;
        found = 1'b0;
        if (heat)
            last_heat_ms = now;
        age = now - last_heat_ms;
        if (age <= TIME_W'(blank_ms))
            return 1'b0;
        div = 64'(ADC_FS) * ((gain_reg == '0) ? 64'd1 : 64'(gain_reg));
        pos = 64'(adc) * FULL_SCALE_MV;
        neg = 64'(offset_mv) * ADC_FS;
        uv = (pos <= neg) ? 64'd0 : ((pos - neg) * UV_PER_MV) / div;
        q = 64'(seg_deg[SEG_LAST]) << Q4_SHIFT;
        if (uv == 0)
            q = 0;
        else if (uv < seg_uv[SEG_LAST])
        begin
            for (int i = 0; i < SEG_LAST && !found; i++)
            begin
                lo = seg_uv[i];
                hi = seg_uv[i+1];
                if (uv >= lo && uv <= hi)
                begin
                    found = 1'b1;
                    q = (64'(seg_deg[i]) << Q4_SHIFT)
                        + ((uv - lo) * (64'(seg_deg[i+1] - seg_deg[i]) << Q4_SHIFT))
                          / (hi - lo);
                end
            end
        end
        temp = OUT_W'(q);
        return 1'b1;
    endfunction

    function automatic void probe(input int offset, input int gain, input int blank,
                                  input int adc, input logic heat, input logic [TIME_W-1:0] now,
                                  input probe_check_t check, input int temp);
        probe_row_t row;
        row.offset = OFFSET_W'(offset);
        row.gain   = GAIN_W'(gain);
        row.blank  = BLANK_W'(blank);
        row.adc    = ADC_W'(adc);
        row.heat   = heat;
        row.now    = now;
        row.check  = check;
        row.temp   = OUT_W'(temp);
        probes.push_back(row);
    endfunction

    // Hold valid with a stable payload until the beat is taken.
    task automatic offer(input logic [ADC_W-1:0] adc, input logic heat,
                         input logic [TIME_W-1:0] now);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        adc_sample <= adc;
        heater_on  <= heat;
        now_ms     <= now;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drain every pending result, then let a blanked item finish.
    task automatic settle();
        in_valid <= 1'b0;
        while (temp_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_settings(input logic [OFFSET_W-1:0] offset,
                                  input logic [GAIN_W-1:0] gain,
                                  input logic [BLANK_W-1:0] blank);
        cfg_we    <= 1'b1;
        cfg_index <= REG_OFFSET;
        cfg_data  <= CFG_DATA_W'(offset);
        @(posedge clk);
        cfg_index <= REG_GAIN;
        cfg_data  <= CFG_DATA_W'(gain);
        @(posedge clk);
        cfg_index <= REG_BLANK;
        cfg_data  <= CFG_DATA_W'(blank);
        @(posedge clk);
        cfg_we    <= 1'b0;
        offset_mv = offset;
        gain_reg  = gain;
        blank_ms  = blank;
    endtask

    task automatic pick_sample(output logic [ADC_W-1:0] adc, output logic heat,
                               output logic [TIME_W-1:0] now);
        int unsigned r;
        r = $urandom_range(0, 99);
        heat = 1'b0;
        if (r < 8)
        begin
            heat = 1'b1;
            clock_ms = clock_ms + $urandom_range(0, 20);
        end
        else if (r < 14)
        begin
            heat = 1'($urandom_range(0, 1));
            clock_ms = $urandom();
        end
        else if (r < 22)
            clock_ms = last_heat_ms + TIME_W'(blank_ms) + $urandom_range(0, 1);
        else if (r < 30)
            clock_ms = clock_ms + $urandom_range(0, blank_ms);
        else
        begin
            clock_ms = clock_ms + $urandom_range(1, 40);
            if (clock_ms - last_heat_ms <= TIME_W'(blank_ms))
                clock_ms = last_heat_ms + TIME_W'(blank_ms) + 1 + $urandom_range(0, 100);
        end
        now = clock_ms;
        r = $urandom_range(0, 99);
        if (r < 5)
            adc = '0;
        else if (r < 10)
            adc = '1;
        else
            adc = ADC_W'($urandom_range(0, 4095));
    endtask

    task automatic random_settings();
        logic [OFFSET_W-1:0] offset;
        logic [GAIN_W-1:0]   gain;
        logic [BLANK_W-1:0]  blank;
        int unsigned         r;
        r = $urandom_range(0, 99);
        offset = (r < 10) ? OFFSET_W'(0) : (r < 14) ? OFFSET_W'(FULL_SCALE_MV)
                                                    : OFFSET_W'($urandom_range(0, 600));
        r = $urandom_range(0, 99);
        gain = (r < 10) ? GAIN_W'(1) : (r < 14) ? GAIN_W'(1000) : (r < 17) ? GAIN_W'(0)
                                               : GAIN_W'($urandom_range(50, 600));
        r = $urandom_range(0, 99);
        blank = (r < 10) ? BLANK_W'(0) : (r < 15) ? BLANK_W'(1000)
                                                  : BLANK_W'($urandom_range(0, 100));
        write_settings(offset, gain, blank);
    endtask

    // Check each output beat against the oldest expected temperature.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (temp_due.size() == 0)
            begin
                $display("%0t: temperature_q4 expected no beat got %0d",
                         $time, temperature_q4);
                mismatches++;
            end
            else
            begin
                if (temperature_q4 !== temp_due[0])
                begin
                    $display("%0t: temperature_q4 expected %0d got %0d",
                             $time, temp_due[0], temperature_q4);
                    mismatches++;
                end
                void'(temp_due.pop_front());
            end
        end
        if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYC;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    initial
    begin
        logic [ADC_W-1:0]  adc;
        logic              heat;
        logic [TIME_W-1:0] now;
        logic [OUT_W-1:0]  temp;
        logic              measured;
        offset_mv    = OFFSET_RESET;
        gain_reg     = GAIN_RESET;
        blank_ms     = BLANK_RESET;
        last_heat_ms = '0;
        clock_ms     = '0;

        // reset values, blanking edge, heater beats
        probe(100, 200, 50, 4095, 1'b0, 32'd0,   CHK_NONE,  0);
        probe(100, 200, 50, 4095, 1'b0, 32'd50,  CHK_NONE,  0);
        probe(100, 200, 50, 4095, 1'b0, 32'd51,  CHK_VALUE, 6080);
        probe(100, 200, 50, 0,    1'b0, 32'd60,  CHK_VALUE, 0);
        probe(100, 200, 50, 124,  1'b0, 32'd61,  CHK_VALUE, 0);
        probe(100, 200, 50, 125,  1'b0, 32'd62,  CHK_MODEL, 0);
        probe(100, 200, 50, 4095, 1'b1, 32'd100, CHK_NONE,  0);
        probe(100, 200, 50, 2000, 1'b0, 32'd150, CHK_NONE,  0);
        probe(100, 200, 50, 2000, 1'b0, 32'd151, CHK_MODEL, 0);
        // land exactly on table points
        probe(0, 880, 0, 273,  1'b0, 32'd152, CHK_VALUE, 38 * 16);
        probe(0, 880, 0, 1092, 1'b0, 32'd153, CHK_VALUE, 84 * 16);
        probe(0, 880, 0, 2184, 1'b0, 32'd154, CHK_VALUE, 134 * 16);
        probe(0, 880, 0, 0,    1'b1, 32'd200, CHK_NONE,  0);
        probe(0, 880, 0, 0,    1'b0, 32'd200, CHK_NONE,  0);
        probe(0, 880, 0, 0,    1'b0, 32'd201, CHK_VALUE, 0);
        probe(0, 55, 0, 546, 1'b0, 32'd300, CHK_VALUE, 6080);
        probe(0, 55, 0, 545, 1'b0, 32'd301, CHK_MODEL, 0);
        // offset beyond full scale, zero gain
        probe(4095, 0, 0, 4095, 1'b0, 32'd302, CHK_VALUE, 0);
        probe(0, 0, 0, 1,    1'b0, 32'd303, CHK_MODEL, 0);
        probe(0, 0, 0, 4095, 1'b0, 32'd304, CHK_VALUE, 6080);
        // longest blanking across the timestamp wrap
        probe(0, 1023, 1023, 4095, 1'b1, 32'hFFFF_FFF0, CHK_NONE,  0);
        probe(0, 1023, 1023, 4095, 1'b0, 32'h0000_0010, CHK_NONE,  0);
        probe(0, 1023, 1023, 4095, 1'b0, 32'h0000_03EF, CHK_NONE,  0);
        probe(0, 1023, 1023, 4095, 1'b0, 32'h0000_03F0, CHK_MODEL, 0);
        probe(0, 1023, 1023, 2048, 1'b0, 32'h8000_0000, CHK_MODEL, 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probes[i])
        begin
            if (probes[i].offset != offset_mv || probes[i].gain != gain_reg
                || probes[i].blank != blank_ms)
            begin
                settle();
                write_settings(probes[i].offset, probes[i].gain, probes[i].blank);
            end
            offer(probes[i].adc, probes[i].heat, probes[i].now);
            measured = linearize_sample(probes[i].adc, probes[i].heat, probes[i].now, temp);
            case (probes[i].check)
                CHK_MODEL: if (measured) temp_due.push_back(temp);
                CHK_VALUE: temp_due.push_back(probes[i].temp);
                default:   ;
            endcase
        end
        clock_ms = probes[probes.size() - 1].now;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            random_settings();
            case (ph % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 67; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 67; end
                default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
            endcase
            // stall the output long enough to back up the input
            if (ph == 4)
                hold_req <= 1'b1;
            repeat (PHASE_LEN)
            begin
                pick_sample(adc, heat, now);
                offer(adc, heat, now);
                if (linearize_sample(adc, heat, now, temp))
                    temp_due.push_back(temp);
            end
        end

        settle();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
